// File: src/stop_word_line_filter_assert.svh
`ifndef STOP_WORD_LINE_FILTER_ASSERT_SVH
`define STOP_WORD_LINE_FILTER_ASSERT_SVH

// same-cycle implication
`define SWLF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swlf assertion failed");

// next-cycle implication
`define SWLF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swlf assertion failed");

`endif

// File: src/swlf_pkg.sv
package swlf_pkg;

   localparam int STOP_PREFIX_CHARS = 5;
   localparam int PREFIX_W          = 8 * STOP_PREFIX_CHARS;
   localparam int STOP_COUNT        = 47;
   localparam logic [15:0] LINE_LIMIT = 16'd16384;
   localparam int FIFO_DEPTH        = 4;
   localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);

   localparam logic [2:0] VERDICT_ACCEPT   = 3'd0;
   localparam logic [2:0] VERDICT_NOT_TWO  = 3'd1;
   localparam logic [2:0] VERDICT_TOO_LONG = 3'd2;
   localparam logic [2:0] VERDICT_SINGLE   = 3'd3;
   localparam logic [2:0] VERDICT_NON_ALPHA = 3'd4;
   localparam logic [2:0] VERDICT_STOP     = 3'd5;

   localparam logic CSR_MAX_WORD_LENGTH  = 1'b0;
   localparam logic CSR_STOP_LIST_ENABLE = 1'b1;

   localparam logic [5:0] MAX_WORD_LENGTH_RST = 6'd45;

   localparam logic [7:0] CHAR_CR  = 8'd13;
   localparam logic [7:0] CHAR_LF  = 8'd10;
   localparam logic [7:0] CHAR_SP  = 8'd32;
   localparam logic [7:0] CHAR_TAB = 8'd9;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [15:0] line_number;
      logic [2:0]  verdict;
      logic [5:0]  first_length;
      logic [15:0] second_offset;
      logic [7:0]  second_length;
   } rsp_type;

   typedef struct packed {
      logic [15:0]         line_number;
      logic [1:0]          token_count;
      logic [6:0]          first_len;
      logic                first_all_letters;
      logic [PREFIX_W-1:0] first_prefix;
      logic [15:0]         second_start;
      logic [7:0]          second_len;
   } line_rec_type;

   typedef struct packed {
      logic [5:0] max_word_length;
      logic       stop_list_enable;
   } cfg_type;

   // right-aligned text, first character in the highest byte of the text
   localparam logic [PREFIX_W-1:0] STOP_TEXT [STOP_COUNT] = '{
      "and", "the", "with", "for", "so", "then", "will", "via", "your", "you",
      "me", "after", "other", "about", "is", "are", "to", "of", "in", "on",
      "nbsp", "was", "www", "very", "that", "she", "or", "more", "just", "it",
      "as", "by", "from", "we", "us", "this", "our", "at", "be", "do",
      "all", "but", "if", "my", "they", "one", "an"
   };

   localparam logic [2:0] STOP_LEN [STOP_COUNT] = '{
      3'd3, 3'd3, 3'd4, 3'd3, 3'd2, 3'd4, 3'd4, 3'd3, 3'd4, 3'd3,
      3'd2, 3'd5, 3'd5, 3'd5, 3'd2, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd4, 3'd3, 3'd3, 3'd4, 3'd4, 3'd3, 3'd2, 3'd4, 3'd4, 3'd2,
      3'd2, 3'd2, 3'd4, 3'd2, 3'd2, 3'd4, 3'd3, 3'd2, 3'd2, 3'd2,
      3'd3, 3'd3, 3'd2, 3'd2, 3'd4, 3'd3, 3'd2
   };

   // reorder so that character i sits at bits 8i
   function automatic logic [PREFIX_W-1:0] pack_word(input logic [PREFIX_W-1:0] s,
                                                     input logic [2:0] n);
      logic [PREFIX_W-1:0] r;
      r = '0;
      for (int i = 0; i < STOP_PREFIX_CHARS; i++) begin
         if (i < int'(n)) begin
            r[8*i +: 8] = s[8*(int'(n)-1-i) +: 8];
         end
      end
      return r;
   endfunction

   function automatic logic stop_hit(input logic [PREFIX_W-1:0] prefix,
                                     input logic [6:0] len);
      logic hit;
      hit = 1'b0;
      for (int w = 0; w < STOP_COUNT; w++) begin
         if (len == {4'd0, STOP_LEN[w]} &&
             prefix == pack_word(STOP_TEXT[w], STOP_LEN[w])) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

// File: src/stop_word_line_filter.sv
// channel   direction  handshake                 payload
// req       in         push / full               req_word  (text_byte, end_of_text)
// rsp       out        pop / empty               rsp_word  (line verdict record)
// csr       in         csr_valid / csr_ready     csr_index, csr_wdata
//
// One byte per cycle while req_full is low; the tokenizer updates in the cycle the byte is taken.
// A line verdict goes from its closing byte into the record queue, then is
// classified into the output register that drives rsp.
// req_full rises only when the 4-entry record queue is full.
// Synchronous reset clears all line state and restores register defaults.
module stop_word_line_filter
   import swlf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_word,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_word,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [5:0] csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   logic         fire, rec_push, rec_pop, q_full, q_empty;
   line_rec_type rec_in_word, rec_out_word;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign fire      = req_push && !q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_WORD_LENGTH:  cfg_in.max_word_length  = csr_wdata;
            CSR_STOP_LIST_ENABLE: cfg_in.stop_list_enable = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_word_length  <= MAX_WORD_LENGTH_RST;
         cfg_ff.stop_list_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swlf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req_word (req_word),
      .rec_push (rec_push),
      .rec_word (rec_in_word)
   );

   swlf_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rec_push),
      .wdata (rec_in_word),
      .pop   (rec_pop),
      .rdata (rec_out_word),
      .full  (q_full),
      .empty (q_empty)
   );

   swlf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .rec_valid (!q_empty),
      .rec_word  (rec_out_word),
      .rec_pop   (rec_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

// File: src/swlf_front.sv
module swlf_front
   import swlf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_type      req_word,
   output logic         rec_push,
   output line_rec_type rec_word
);

   logic [15:0]         line_count_ff, line_count_in;
   logic                line_open_ff, line_open_in;
   logic                in_token_ff, in_token_in;
   logic [1:0]          token_count_ff, token_count_in;
   logic [6:0]          first_len_ff, first_len_in;
   logic                first_all_letters_ff, first_all_letters_in;
   logic [PREFIX_W-1:0] first_prefix_ff, first_prefix_in;
   logic [15:0]         byte_offset_ff, byte_offset_in;
   logic [15:0]         second_start_ff, second_start_in;
   logic [7:0]          second_len_ff, second_len_in;

   logic [7:0]          b;
   logic                eol, sep, letter, closing, emit;
   logic [15:0]         lc_inc, off_inc;
   logic                it_upd;
   logic [1:0]          tc_upd;
   logic [6:0]          fl_upd;
   logic                fal_upd;
   logic [PREFIX_W-1:0] fp_upd;
   logic [15:0]         ss_upd;
   logic [7:0]          sl_upd;

   assign b      = req_word.text_byte;
   assign eol    = (b == CHAR_CR) || (b == CHAR_LF);
   assign sep    = (b == CHAR_SP) || (b == CHAR_TAB);
   assign letter = (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);

   always_comb begin
      it_upd  = in_token_ff;
      tc_upd  = token_count_ff;
      fl_upd  = first_len_ff;
      fal_upd = first_all_letters_ff;
      fp_upd  = first_prefix_ff;
      ss_upd  = second_start_ff;
      sl_upd  = second_len_ff;
      if (!eol) begin
         if (sep) begin
            it_upd = 1'b0;
         end else begin
            if (!in_token_ff) begin
               it_upd = 1'b1;
               if (token_count_ff != 2'd3) begin
                  tc_upd = token_count_ff + 2'd1;
               end
               if (tc_upd == 2'd2) begin
                  ss_upd = byte_offset_ff;
               end
            end
            if (tc_upd == 2'd1) begin
               for (int i = 0; i < STOP_PREFIX_CHARS; i++) begin
                  if (first_len_ff == 7'(i)) begin
                     fp_upd[8*i +: 8] = b;
                  end
               end
               if (first_len_ff != 7'd64) begin
                  fl_upd = first_len_ff + 7'd1;
               end
               if (!letter) begin
                  fal_upd = 1'b0;
               end
            end else if (tc_upd == 2'd2) begin
               if (second_len_ff != 8'hFF) begin
                  sl_upd = second_len_ff + 8'd1;
               end
            end
         end
      end
   end

   assign lc_inc  = (line_count_ff == 16'hFFFF) ? line_count_ff : line_count_ff + 16'd1;
   assign off_inc = (byte_offset_ff == 16'hFFFF) ? byte_offset_ff : byte_offset_ff + 16'd1;
   assign closing = eol ? line_open_ff : req_word.end_of_text;
   assign emit    = closing && (lc_inc <= LINE_LIMIT);

   assign rec_push                   = fire && emit;
   assign rec_word.line_number       = lc_inc;
   assign rec_word.token_count       = tc_upd;
   assign rec_word.first_len         = fl_upd;
   assign rec_word.first_all_letters = fal_upd;
   assign rec_word.first_prefix      = fp_upd;
   assign rec_word.second_start      = ss_upd;
   assign rec_word.second_len        = sl_upd;

   always_comb begin
      line_count_in        = line_count_ff;
      line_open_in         = line_open_ff;
      in_token_in          = in_token_ff;
      token_count_in       = token_count_ff;
      first_len_in         = first_len_ff;
      first_all_letters_in = first_all_letters_ff;
      first_prefix_in      = first_prefix_ff;
      byte_offset_in       = byte_offset_ff;
      second_start_in      = second_start_ff;
      second_len_in        = second_len_ff;
      if (fire) begin
         if (closing) begin
            line_open_in         = 1'b0;
            in_token_in          = 1'b0;
            token_count_in       = 2'd0;
            first_len_in         = 7'd0;
            first_all_letters_in = 1'b1;
            first_prefix_in      = '0;
            second_start_in      = 16'd0;
            second_len_in        = 8'd0;
            line_count_in        = lc_inc;
         end else begin
            line_open_in         = line_open_ff || !eol;
            in_token_in          = it_upd;
            token_count_in       = tc_upd;
            first_len_in         = fl_upd;
            first_all_letters_in = fal_upd;
            first_prefix_in      = fp_upd;
            second_start_in      = ss_upd;
            second_len_in        = sl_upd;
         end
         byte_offset_in = off_inc;
         if (req_word.end_of_text) begin
            line_open_in         = 1'b0;
            in_token_in          = 1'b0;
            token_count_in       = 2'd0;
            first_len_in         = 7'd0;
            first_all_letters_in = 1'b1;
            first_prefix_in      = '0;
            second_start_in      = 16'd0;
            second_len_in        = 8'd0;
            line_count_in        = 16'd0;
            byte_offset_in       = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff        <= 16'd0;
         line_open_ff         <= 1'b0;
         in_token_ff          <= 1'b0;
         token_count_ff       <= 2'd0;
         first_len_ff         <= 7'd0;
         first_all_letters_ff <= 1'b1;
         first_prefix_ff      <= '0;
         byte_offset_ff       <= 16'd0;
         second_start_ff      <= 16'd0;
         second_len_ff        <= 8'd0;
      end else begin
         line_count_ff        <= line_count_in;
         line_open_ff         <= line_open_in;
         in_token_ff          <= in_token_in;
         token_count_ff       <= token_count_in;
         first_len_ff         <= first_len_in;
         first_all_letters_ff <= first_all_letters_in;
         first_prefix_ff      <= first_prefix_in;
         byte_offset_ff       <= byte_offset_in;
         second_start_ff      <= second_start_in;
         second_len_ff        <= second_len_in;
      end
   end

endmodule

// File: src/swlf_fifo.sv
module swlf_fifo
   import swlf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  line_rec_type wdata,
   input  logic         pop,
   output line_rec_type rdata,
   output logic         full,
   output logic         empty
);

   line_rec_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]       count_ff, count_in;
   logic                      do_push, do_pop;

   assign full    = (count_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/swlf_back.sv
module swlf_back
   import swlf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         rec_valid,
   input  line_rec_type rec_word,
   output logic         rec_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_type      rsp_word
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    load, two_plus;
   logic [2:0] verdict;

   assign two_plus = rec_word.token_count[1];

   always_comb begin
      if (rec_word.token_count != 2'd2) begin
         verdict = VERDICT_NOT_TWO;
      end else if (rec_word.first_len > {1'b0, cfg.max_word_length}) begin
         verdict = VERDICT_TOO_LONG;
      end else if (rec_word.first_len == 7'd1) begin
         verdict = VERDICT_SINGLE;
      end else if (!rec_word.first_all_letters) begin
         verdict = VERDICT_NON_ALPHA;
      end else if (cfg.stop_list_enable &&
                   stop_hit(rec_word.first_prefix, rec_word.first_len)) begin
         verdict = VERDICT_STOP;
      end else begin
         verdict = VERDICT_ACCEPT;
      end
   end

   assign load    = rec_valid && (!out_valid_ff || rsp_pop);
   assign rec_pop = load;

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in         = 1'b1;
         out_in.line_number   = rec_word.line_number;
         out_in.verdict       = verdict;
         out_in.first_length  = rec_word.first_len[6] ? 6'd63 : rec_word.first_len[5:0];
         out_in.second_offset = two_plus ? rec_word.second_start : 16'd0;
         out_in.second_length = two_plus ? rec_word.second_len : 8'd0;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_word  = out_ff;

endmodule

// File: src/swlf_checker.sv
`include "stop_word_line_filter_assert.svh"

module swlf_checker
   import swlf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_word
);

   logic rsp_wait, rsp_accept, accept_shape;

   assign rsp_wait     = !rsp_empty && !rsp_pop;
   assign rsp_accept   = !rsp_empty && (rsp_word.verdict == VERDICT_ACCEPT);
   assign accept_shape = (rsp_word.first_length >= 6'd2) && (rsp_word.second_length != 8'd0) &&
                         (rsp_word.line_number != 16'd0);

   `SWLF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, !rsp_empty && $stable(rsp_word))

   `SWLF_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, rsp_empty && !req_full)

   `SWLF_ASSERT_NOW(a_verdict_code, clock, reset, !rsp_empty, rsp_word.verdict <= VERDICT_STOP)

   `SWLF_ASSERT_NOW(a_accept_shape, clock, reset, rsp_accept, accept_shape)

endmodule

bind stop_word_line_filter swlf_checker u_swlf_checker (.*);

// File: sim/tb_stop_word_line_filter.sv
`timescale 1ns / 100ps

module tb_stop_word_line_filter;
   import swlf_pkg::*;

   localparam int PREFIX_CHARS    = 5;
   localparam int REPORTED_LINES  = 16384;
   localparam int STOP_WORD_COUNT = 47;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASE_BYTES     = 270;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_push    = 1'b0;
   logic       req_full;
   req_type    req_word    = '0;
   logic       rsp_empty;
   logic       rsp_pop     = 1'b0;
   rsp_type    rsp_word;
   logic       csr_valid   = 1'b0;
   logic       csr_ready;
   logic       csr_index   = 1'b0;
   logic [5:0] csr_wdata   = '0;

   string stop_words [STOP_WORD_COUNT] = '{
      "and", "the", "with", "for", "so", "then", "will", "via", "your", "you",
      "me", "after", "other", "about", "is", "are", "to", "of", "in", "on",
      "nbsp", "was", "www", "very", "that", "she", "or", "more", "just", "it",
      "as", "by", "from", "we", "us", "this", "our", "at", "be", "do",
      "all", "but", "if", "my", "they", "one", "an"
   };

   req_type     pending_bytes [$];
   rsp_type     line_verdicts [$];
   logic [7:0]  line_bytes [$];
   int unsigned queued_bytes = 0;
   int unsigned mismatches   = 0;

   // predicted block state
   logic [5:0]  cfg_max_len  = MAX_WORD_LENGTH_RST;
   logic        cfg_stop_en  = 1'b1;
   int unsigned lines_seen   = 0;
   bit          line_active  = 1'b0;
   bit          token_active = 1'b0;
   int unsigned tokens_seen  = 0;
   int unsigned first_cnt    = 0;
   bit          first_alpha  = 1'b1;
   logic [8*PREFIX_CHARS-1:0] first_chars = '0;
   int unsigned offset_now   = 0;
   int unsigned second_at    = 0;
   int unsigned second_cnt   = 0;

   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;
   bit [15:0]   stall_pat  = 16'hFFFF;
   int unsigned pat_age    = 0;

   stop_word_line_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit alpha_byte(input logic [7:0] b);
      return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
   endfunction

   function automatic bit hits_stop_list();
      bit same;
      if (first_cnt > PREFIX_CHARS) return 1'b0;
      foreach (stop_words[w]) begin
         if (stop_words[w].len() == first_cnt) begin
            same = 1'b1;
            for (int i = 0; i < first_cnt; i++) begin
               if (first_chars[8*i +: 8] != stop_words[w][i]) same = 1'b0;
            end
            if (same) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic reset_line_state();
      line_active  = 1'b0;
      token_active = 1'b0;
      tokens_seen  = 0;
      first_cnt    = 0;
      first_alpha  = 1'b1;
      first_chars  = '0;
      second_at    = 0;
      second_cnt   = 0;
   endtask

   task automatic end_line();
      rsp_type word;
      if (!line_active) return;
      if (lines_seen < 65535) lines_seen++;
      if (lines_seen > REPORTED_LINES) begin
         reset_line_state();
         return;
      end
      if (tokens_seen != 2) word.verdict = VERDICT_NOT_TWO;
      else if (first_cnt > cfg_max_len) word.verdict = VERDICT_TOO_LONG;
      else if (first_cnt == 1) word.verdict = VERDICT_SINGLE;
      else if (!first_alpha) word.verdict = VERDICT_NON_ALPHA;
      else if (cfg_stop_en && hits_stop_list()) word.verdict = VERDICT_STOP;
      else word.verdict = VERDICT_ACCEPT;
      word.line_number   = lines_seen[15:0];
      word.first_length  = (first_cnt > 63) ? 6'd63 : first_cnt[5:0];
      word.second_offset = (tokens_seen >= 2) ? second_at[15:0] : 16'd0;
      word.second_length = (tokens_seen >= 2) ? second_cnt[7:0] : 8'd0;
      line_verdicts.push_back(word);
      reset_line_state();
   endtask

   task automatic take_byte(input req_type w);
      logic [7:0] b;
      b = w.text_byte;
      if (b == CHAR_CR || b == CHAR_LF) begin
         end_line();
      end else begin
         line_active = 1'b1;
         if (b == CHAR_SP || b == CHAR_TAB) begin
            token_active = 1'b0;
         end else begin
            if (!token_active) begin
               token_active = 1'b1;
               if (tokens_seen < 3) tokens_seen++;
               if (tokens_seen == 2) second_at = offset_now;
            end
            if (tokens_seen == 1) begin
               if (first_cnt < PREFIX_CHARS) first_chars[8*first_cnt +: 8] = b;
               if (first_cnt < 64) first_cnt++;
               if (!alpha_byte(b)) first_alpha = 1'b0;
            end else if (tokens_seen == 2) begin
               if (second_cnt < 255) second_cnt++;
            end
         end
      end
      if (offset_now < 65535) offset_now++;
      if (w.end_of_text) begin
         end_line();
         reset_line_state();
         lines_seen = 0;
         offset_now = 0;
      end
   endtask

   function automatic logic [7:0] sep_char();
      return $urandom_range(0, 1) ? CHAR_SP : CHAR_TAB;
   endfunction

   function automatic logic [7:0] word_char(input bit mixed);
      logic [7:0] odd [8] = '{8'd0, 8'd64, 8'd91, 8'd96, 8'd123, 8'd255, 8'd48, 8'd127};
      logic [7:0] c;
      if (!mixed || $urandom_range(0, 2) != 0) begin
         c = 8'($urandom_range(0, 25));
         return ($urandom_range(0, 1) ? 8'd65 : 8'd97) + c;
      end
      if ($urandom_range(0, 1)) return odd[$urandom_range(0, 7)];
      do c = 8'($urandom_range(0, 255));
      while (c == CHAR_SP || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF);
      return c;
   endfunction

   task automatic stage_text(input string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endtask

   task automatic stage_token(input int len, input bit mixed);
      repeat (len) line_bytes.push_back(word_char(mixed));
   endtask

   task automatic flush_line(input bit eot);
      req_type w;
      foreach (line_bytes[i]) begin
         w.text_byte   = line_bytes[i];
         w.end_of_text = eot && (i == line_bytes.size() - 1);
         pending_bytes.push_back(w);
      end
      queued_bytes += line_bytes.size();
      line_bytes.delete();
   endtask

   task automatic queue_line();
      int    kind;
      int    ntok;
      int    pick;
      int    len;
      int    term;
      string w;
      kind = $urandom_range(0, 99);
      if (kind < 60) ntok = 2;
      else if (kind < 72) ntok = $urandom_range(3, 5);
      else if (kind < 80) ntok = 1;
      else if (kind < 88) ntok = 0;
      else ntok = -1;
      if (ntok < 0) begin
         repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) line_bytes.push_back(sep_char());
         end
         for (int t = 0; t < ntok; t++) begin
            if (t != 0) repeat ($urandom_range(1, 3)) line_bytes.push_back(sep_char());
            if (t == 0) begin
               pick = $urandom_range(0, 9);
               if (pick < 3) begin
                  w = stop_words[$urandom_range(0, STOP_WORD_COUNT - 1)];
                  // capitalized or lengthened stop words must pass
                  if (pick == 0 && $urandom_range(0, 1)) w[0] = w[0] - 8'd32;
                  stage_text(w);
                  if (pick == 1 && $urandom_range(0, 1)) line_bytes.push_back(word_char(1'b0));
               end else if (pick == 7) begin
                  stage_token($urandom_range(40, 70), 1'b0);
               end else if (pick == 8) begin
                  stage_token($urandom_range(1, 6), 1'b1);
               end else begin
                  stage_token($urandom_range(1, 8), 1'b0);
               end
            end else begin
               len = ($urandom_range(0, 99) == 0) ? $urandom_range(200, 300)
                                                  : $urandom_range(1, 10);
               stage_token(len, $urandom_range(0, 3) == 0);
            end
         end
         if ($urandom_range(0, 3) == 0) line_bytes.push_back(sep_char());
      end
      term = $urandom_range(0, 9);
      if (term < 6) begin
         line_bytes.push_back(CHAR_LF);
      end else if (term < 8) begin
         line_bytes.push_back(CHAR_CR);
      end else if (term == 8) begin
         line_bytes.push_back(CHAR_CR);
         line_bytes.push_back(CHAR_LF);
      end else begin
         line_bytes.push_back(CHAR_LF);
         line_bytes.push_back(CHAR_LF);
      end
      if ($urandom_range(0, 19) == 0) begin
         if ($urandom_range(0, 1) && line_bytes.size() > 1) void'(line_bytes.pop_back());
         flush_line(1'b1);
      end else begin
         flush_line(1'b0);
      end
   endtask

   task automatic write_register(input logic idx, input logic [5:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MAX_WORD_LENGTH) cfg_max_len = data;
      else cfg_stop_en = data[0];
   endtask

   task automatic settle();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_push || line_verdicts.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // sender: bursts of random length, random gaps
   always @(posedge clock) begin
      bit go;
      if (req_push && !req_full) take_byte(pending_bytes.pop_front());
      go = 1'b0;
      if (!reset && pending_bytes.size() != 0) begin
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
         if (burst_left != 0) begin
            go = 1'b1;
            burst_left--;
         end else begin
            gap_left--;
         end
      end
      req_push <= go;
      if (go) req_word <= pending_bytes[0];
   end

   // receiver: rotating pop pattern, reshuffled now and then
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (line_verdicts.size() == 0) begin
            mismatches++;
            $error("unexpected word: line_number %0d", rsp_word.line_number);
         end else begin
            want = line_verdicts.pop_front();
            check_field("line_number", want.line_number, rsp_word.line_number);
            check_field("verdict", 16'(want.verdict), 16'(rsp_word.verdict));
            check_field("first_length", 16'(want.first_length), 16'(rsp_word.first_length));
            check_field("second_offset", want.second_offset, rsp_word.second_offset);
            check_field("second_length", 16'(want.second_length),
                        16'(rsp_word.second_length));
         end
      end
      if (pat_age == 0) begin
         pat_age = $urandom_range(16, 400);
         case ($urandom_range(0, 3))
            0: stall_pat = 16'hFFFF;
            1: stall_pat = 16'($urandom) | (16'h1 << $urandom_range(0, 15));
            2: stall_pat = 16'($urandom & $urandom) | (16'h1 << $urandom_range(0, 15));
            default: stall_pat = 16'h8000 >> $urandom_range(0, 15);
         endcase
      end else begin
         pat_age--;
      end
      stall_pat = {stall_pat[14:0], stall_pat[15]};
      rsp_pop <= stall_pat[0];
   end

   initial begin
      logic [5:0]  lim;
      bit          en;
      int unsigned target;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // stop word, CRLF, single letter, non-letters, one token, zero byte, end of text
      stage_text("an\tz\r\n");
      stage_text("a b\n");
      stage_text("Z");
      line_bytes.push_back(8'hFF);
      stage_text(" q\n");
      stage_text("ok\n");
      stage_text("By ");
      line_bytes.push_back(8'h00);
      flush_line(1'b1);

      for (int p = 0; p < 6; p++) begin
         settle();
         case (p)
            0: begin lim = 6'd0;  en = 1'b1; end
            1: begin lim = 6'd63; en = 1'b0; end
            2: begin lim = 6'd1;  en = 1'b1; end
            3: begin lim = 6'd2;  en = 1'b0; end
            default: begin
               lim = 6'($urandom_range(3, 62));
               en  = 1'($urandom_range(0, 1));
            end
         endcase
         write_register(CSR_MAX_WORD_LENGTH, lim);
         write_register(CSR_STOP_LIST_ENABLE, {5'($urandom_range(0, 31)), en});
         target = queued_bytes + PHASE_BYTES;
         while (queued_bytes < target) queue_line();
      end

      // defaults again, a text closed by end of text, then a fresh line
      settle();
      write_register(CSR_MAX_WORD_LENGTH, 6'd45);
      write_register(CSR_STOP_LIST_ENABLE, 6'd1);
      stage_text("ab c");
      flush_line(1'b1);
      stage_text("xy z\n");
      flush_line(1'b0);

      settle();
      if (mismatches == 0) begin
         $display("stop_word_line_filter: match");
      end else begin
         $display("stop_word_line_filter: mismatch");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("stop_word_line_filter: mismatch");
      $finish;
   end

endmodule
